// ----- sv/interpolation_search_assert.svh -----
// ----------------------------------------------------------------------------
// interpolation search assertion macros
// shared concurrent check forms, clocked on i_clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef INTERPOLATION_SEARCH_ASSERT_SVH
`define INTERPOLATION_SEARCH_ASSERT_SVH

// same-cycle implication
`define IS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/is_pkg.sv -----
// ----------------------------------------------------------------------------
// is_pkg
// types and fixed constants shared by the interpolation search modules
// ----------------------------------------------------------------------------
`default_nettype none

package is_pkg;

    localparam int DATA_W   = 32;
    localparam int IN_IDX_W = 5;
    localparam int CNT_W    = 6;

    localparam logic [CNT_W-1:0] ENTRIES_RESET = 6'd20;

    // function code of an input item
    localparam logic FUNC_SEARCH = 1'b1;

    // front queue between intake and search engine
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_SEARCH = 1'b1
    } t_kind;

    // value carries entry_value for a load and search_key for a search
    typedef struct packed {
        t_kind                kind;
        logic [IN_IDX_W-1:0]  index;
        logic [DATA_W-1:0]    value;
    } t_qentry;

    typedef struct packed {
        logic    valid;
        t_qentry entry;
    } t_qhead;

    typedef struct packed {
        logic                found;
        logic [IN_IDX_W-1:0] found_index;
        logic [CNT_W-1:0]    probe_count;
    } t_result;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_LO,
        ST_RD_HI,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_RD_MID,
        ST_CMP,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- sv/is_queue.sv -----
// ----------------------------------------------------------------------------
// is_queue
// intake side: accepts items, drops loads beyond the table, queues the rest
// ----------------------------------------------------------------------------
`default_nettype none
`include "interpolation_search_assert.svh"

module is_queue #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic                                i_func,
    input  logic        [is_pkg::IN_IDX_W-1:0]  i_entry_index,
    input  logic signed [is_pkg::DATA_W-1:0]    i_entry_value,
    input  logic signed [is_pkg::DATA_W-1:0]    i_search_key,
    output is_pkg::t_qhead                      o_head,
    input  logic                                i_deq
);
    import is_pkg::*;

    t_qentry             r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic [Q_CNT_W-1:0]  n_count;
    logic                w_accept;
    logic                w_keep;
    logic                w_enq;
    logic                w_deq;
    t_qentry             w_new;

    assign o_full   = (r_count == Q_CNT_W'(Q_DEPTH));
    assign w_accept = i_push && !o_full;
    // a load aimed past the table is taken and then dropped
    assign w_keep   = (i_func == FUNC_SEARCH) ||
                      (32'(i_entry_index) < 32'(TABLE_DEPTH));
    assign w_enq    = w_accept && w_keep;
    assign w_deq    = i_deq && (r_count != '0);

    always_comb begin
        w_new.index = i_entry_index;
        if (i_func == FUNC_SEARCH) begin
            w_new.kind  = KIND_SEARCH;
            w_new.value = i_search_key;
        end else begin
            w_new.kind  = KIND_LOAD;
            w_new.value = i_entry_value;
        end
    end

    always_comb begin
        case ({w_enq, w_deq})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_enq) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_deq) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_slot[r_wr_ptr] <= w_new;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_slot[r_rd_ptr];

    `IS_ASSERT_NXT(a_head_holds, (r_count != '0) && !w_deq, $stable(o_head.entry), "queue head changed without a dequeue")

endmodule

`default_nettype wire

// ----- sv/is_div.sv -----
// ----------------------------------------------------------------------------
// is_div
// restoring divider, one quotient bit a cycle, quotient known to fit q_w bits
// ----------------------------------------------------------------------------
`default_nettype none

module is_div #(
    parameter int Q_W = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [is_pkg::DATA_W+Q_W-1:0]     i_dividend,
    input  logic [is_pkg::DATA_W-1:0]         i_divisor,
    output logic [Q_W-1:0]                    o_quot,
    output is_pkg::t_div_stat                 o_stat
);
    import is_pkg::*;

    localparam int P_W    = DATA_W + Q_W;
    localparam int STEP_W = $clog2(Q_W + 1);

    logic [P_W-1:0]    r_rem;
    logic [P_W-1:0]    r_den;
    logic [Q_W-1:0]    r_quot;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic              w_bit;

    assign w_bit = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(Q_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_den  <= P_W'(i_divisor) << (Q_W - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_bit) begin
                r_rem <= r_rem - r_den;
            end
            r_den  <= r_den >> 1;
            r_quot <= (r_quot << 1) | Q_W'(w_bit);
        end
    end

    assign o_quot      = r_quot;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// ----- sv/is_back.sv -----
// ----------------------------------------------------------------------------
// is_back
// search engine: table memory, bounds check, probe arithmetic, result hold
// ----------------------------------------------------------------------------
`default_nettype none
`include "interpolation_search_assert.svh"

module is_back #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  is_pkg::t_qhead                i_head,
    output logic                          o_deq,
    input  logic [is_pkg::CNT_W-1:0]      i_entries_in_use,
    output is_pkg::t_result               o_res,
    output logic                          o_res_valid,
    input  logic                          i_pop
);
    import is_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int PROD_W = DATA_W + IDX_W;

    t_state                   r_state;
    t_state                   n_state;

    logic [DATA_W-1:0]        r_table [TABLE_DEPTH];
    logic [DATA_W-1:0]        r_rd_data;
    logic [IDX_W-1:0]         w_rd_addr;
    logic                     w_wr_en;

    logic signed [DATA_W-1:0] r_key,   n_key;
    logic signed [DATA_W-1:0] r_tlo,   n_tlo;
    logic [DATA_W-1:0]        r_num,   n_num;
    logic [DATA_W-1:0]        r_den,   n_den;
    logic [IDX_W-1:0]         r_span,  n_span;
    logic [IDX_W-1:0]         r_lo,    n_lo;
    logic [IDX_W-1:0]         r_hi,    n_hi;
    logic [IDX_W-1:0]         r_mid,   n_mid;
    logic [IDX_W-1:0]         r_fidx,  n_fidx;
    logic [CNT_W-1:0]         r_probes, n_probes;
    logic                     r_found, n_found;

    logic signed [DATA_W-1:0] w_tcur;
    logic [PROD_W-1:0]        w_dividend;
    logic [IDX_W-1:0]         w_quot;
    logic                     w_div_start;
    t_div_stat                w_div_stat;

    assign w_tcur     = r_rd_data;
    assign w_dividend = r_span * r_num;

    is_div #(
        .Q_W (IDX_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_den),
        .o_quot     (w_quot),
        .o_stat     (w_div_stat)
    );

    always_comb begin
        case (r_state)
            ST_RD_LO: w_rd_addr = r_lo;
            ST_RD_HI: w_rd_addr = r_hi;
            default:  w_rd_addr = r_mid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_table[IDX_W'(i_head.entry.index)] <= i_head.entry.value;
        end
        r_rd_data <= r_table[w_rd_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_tlo       = r_tlo;
        n_num       = r_num;
        n_den       = r_den;
        n_span      = r_span;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_fidx      = r_fidx;
        n_probes    = r_probes;
        n_found     = r_found;
        o_deq       = 1'b0;
        w_wr_en     = 1'b0;
        w_div_start = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_deq = 1'b1;
                    if (i_head.entry.kind == KIND_LOAD) begin
                        w_wr_en = 1'b1;
                    end else begin
                        n_key    = i_head.entry.value;
                        n_probes = '0;
                        n_found  = 1'b0;
                        n_fidx   = '0;
                        n_lo     = '0;
                        // entry count saturates at the table depth
                        if (32'(i_entries_in_use) > 32'(TABLE_DEPTH)) begin
                            n_hi = IDX_W'(TABLE_DEPTH - 1);
                        end else begin
                            n_hi = IDX_W'(i_entries_in_use - 1'b1);
                        end
                        n_state = (i_entries_in_use == '0) ? ST_OUT : ST_RD_LO;
                    end
                end
            end
            ST_RD_LO: begin
                n_state = ST_RD_HI;
            end
            ST_RD_HI: begin
                n_tlo   = w_tcur;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                // w_tcur holds t[hi] here
                if (r_key < r_tlo || r_key > w_tcur) begin
                    n_state = ST_OUT;
                end else if (w_tcur == r_tlo) begin
                    n_mid   = r_lo;
                    n_state = ST_RD_MID;
                end else begin
                    n_num   = DATA_W'(r_key - r_tlo);
                    n_den   = DATA_W'(w_tcur - r_tlo);
                    n_span  = r_hi - r_lo;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_stat.done) begin
                    n_mid   = r_lo + w_quot;
                    n_state = ST_RD_MID;
                end
            end
            ST_RD_MID: begin
                n_probes = r_probes + 1'b1;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                if (w_tcur == r_key) begin
                    n_found = 1'b1;
                    n_fidx  = r_mid;
                    n_state = ST_OUT;
                end else if (w_tcur < r_key) begin
                    if (r_mid == r_hi) begin
                        n_state = ST_OUT;
                    end else begin
                        n_lo    = r_mid + 1'b1;
                        n_state = ST_RD_LO;
                    end
                end else begin
                    if (r_mid == r_lo) begin
                        n_state = ST_OUT;
                    end else begin
                        n_hi    = r_mid - 1'b1;
                        n_state = ST_RD_LO;
                    end
                end
            end
            ST_OUT: begin
                o_res_valid = 1'b1;
                if (i_pop) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_tlo    <= n_tlo;
        r_num    <= n_num;
        r_den    <= n_den;
        r_span   <= n_span;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_fidx   <= n_fidx;
        r_probes <= n_probes;
        r_found  <= n_found;
    end

    assign o_res.found       = r_found;
    assign o_res.found_index = IN_IDX_W'(r_fidx);
    assign o_res.probe_count = r_probes;

    `IS_ASSERT_IMP(a_mid_in_range, r_state == ST_RD_MID, (r_mid >= r_lo) && (r_mid <= r_hi), "probe position left the search range")
    `IS_ASSERT_IMP(a_range_ordered, r_state == ST_RD_LO, r_lo <= r_hi, "search range empty at a new probe")
    `IS_ASSERT_IMP(a_div_only_waited, w_div_stat.done, r_state == ST_DIV, "divider finished outside the wait state")
    `IS_ASSERT_IMP(a_div_running, r_state == ST_DIV, w_div_stat.busy || w_div_stat.done, "waiting on an idle divider")

endmodule

`default_nettype wire

// ----- sv/interpolation_search.sv -----
// order: a load item leaves the queue and is written in the same cycle; a search item
//   gives its result once a probe hits the key, a bounds check fails, the range runs
//   out or no entry is in use, and holds it until popped
// concurrency: one item at a time in the search engine; each probe off a flat range is
//   set by the restoring divider, one quotient bit a cycle, and one table read port
// reset: synchronous; queues empty, entries_in_use back to 20, table undefined, no sweep
// ----------------------------------------------------------------------------
// interpolation_search
// interpolation search over a loadable sorted table of signed 32-bit words
// ----------------------------------------------------------------------------
`default_nettype none

module interpolation_search #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item queue side
    input  logic                                push,
    output logic                                full,
    input  logic                                i_func,
    input  logic        [is_pkg::IN_IDX_W-1:0]  i_entry_index,
    input  logic signed [is_pkg::DATA_W-1:0]    i_entry_value,
    input  logic signed [is_pkg::DATA_W-1:0]    i_search_key,
    // result queue side
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_found,
    output logic        [is_pkg::IN_IDX_W-1:0]  o_found_index,
    output logic        [is_pkg::CNT_W-1:0]     o_probe_count,
    // configuration write channel
    input  logic                                valid,
    output logic                                ready,
    input  logic        [is_pkg::CNT_W-1:0]     i_entries_in_use
);
    import is_pkg::*;

    // number of entries searched, from index zero
    logic [CNT_W-1:0] r_entries_in_use;

    t_qhead           w_head;
    logic             w_deq;
    t_result          w_res;
    logic             w_res_valid;

    // always writable; writes must land only while idle: the user's duty, unenforced
    assign ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= ENTRIES_RESET;
        end else if (valid && ready) begin
            r_entries_in_use <= i_entries_in_use;
        end
    end

    // front: takes items, drops loads past the table, buffers the rest so intake
    // keeps going, until the queue fills, while a finished result waits to be popped
    is_queue #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_func        (i_func),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_search_key  (i_search_key),
        .o_head        (w_head),
        .i_deq         (w_deq)
    );

    // back: table memory and the probe loop, result held until popped
    is_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (w_head),
        .o_deq            (w_deq),
        .i_entries_in_use (r_entries_in_use),
        .o_res            (w_res),
        .o_res_valid      (w_res_valid),
        .i_pop            (pop)
    );

    // a result shows while empty is low
    assign empty         = !w_res_valid;
    assign o_found       = w_res.found;
    assign o_found_index = w_res.found_index;
    assign o_probe_count = w_res.probe_count;

endmodule

`default_nettype wire
